// ===== rtl/e2e1_pkg.sv =====
// shared types, codes and the crc-8 helpers for the e2e profile 1 frame checker
// no dependencies; imported by the top, front and back modules of the block

package e2e1_pkg;

	localparam logic [7:0] CRC_POLY = 8'h1D;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_DATA_ID           = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DATA_LENGTH       = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CRC_OFFSET        = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_COUNTER_OFFSET    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELTA_COUNTER = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_SYNC_COUNTER_INIT = 3'd5;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_OKSOMELOST    = 3'd1,
		ST_WRONGCRC      = 3'd2,
		ST_REPEATED      = 3'd3,
		ST_WRONGSEQUENCE = 3'd4,
		ST_SYNC          = 3'd5,
		ST_INITIAL       = 3'd6,
		ST_ERROR         = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] crc_id;
		logic [7:0] data_length;
		logic [7:0] crc_offset;
		logic [7:0] counter_offset;
		logic [3:0] max_delta_counter;
		logic [7:0] sync_counter_init;
	} cfg_t;

	// what the front hands over at each frame end
	typedef struct packed {
		logic       short_frame;
		logic       crc_ok;
		logic [3:0] counter;
	} frame_rec_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] counter;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// crc over the id, low byte first; linear in the id bits, so it flattens to xor trees
	function automatic logic [7:0] crc8_id(input logic [15:0] id);
		return crc8_byte(crc8_byte(8'h00, id[7:0]), id[15:8]);
	endfunction

endpackage

// ===== rtl/e2e_profile1_frame_checker_top.sv =====
// Receive-side e2e profile 1 checker. Bytes of a pdu enter one per cycle through a
// push/full queue interface, frame_end flagging the last byte; each frame end yields
// one status and counter on the empty/pop result side. The front end takes a byte
// every cycle (crc-8 0x1D over id and protected bytes, one unrolled byte step per
// cycle) and hands a frame record to a short queue; the back end judges one record
// per cycle while the result queue has room and writes it, so input only stalls when
// the frame queue is full. A record waits in the frame queue and its result in the
// result queue before it shows on the result ports. Configuration must be written
// via cfg_we/cfg_addr/cfg_wdata only while the block is idle; nothing enforces it.
// depends on e2e1_pkg, e2e1_fifo, e2e1_front, e2e1_back

module e2e_profile1_frame_checker_top
	import e2e1_pkg::*;
#(
	parameter int FRAME_QUEUE_DEPTH  = 4,
	parameter int RESULT_QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            data_byte,
	input  logic                  frame_end,
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            check_status,
	output logic [3:0]            received_counter
);

	cfg_t       cfg_q;
	logic       accept;
	logic       rec_valid;
	frame_rec_t rec_in;
	frame_rec_t rec_out;
	logic       frq_empty;
	logic       rq_full;
	logic       take;
	result_t    res_in;
	result_t    res_out;

	// the id is kept only as its crc, worked out when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_id            <= crc8_id(16'h0000);
			cfg_q.data_length       <= 8'd8;
			cfg_q.crc_offset        <= 8'd0;
			cfg_q.counter_offset    <= 8'd1;
			cfg_q.max_delta_counter <= 4'd1;
			cfg_q.sync_counter_init <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DATA_ID:           cfg_q.crc_id            <= crc8_id(cfg_wdata);
				REG_DATA_LENGTH:       cfg_q.data_length       <= cfg_wdata[7:0];
				REG_CRC_OFFSET:        cfg_q.crc_offset        <= cfg_wdata[7:0];
				REG_COUNTER_OFFSET:    cfg_q.counter_offset    <= cfg_wdata[7:0];
				REG_MAX_DELTA_COUNTER: cfg_q.max_delta_counter <= cfg_wdata[3:0];
				REG_SYNC_COUNTER_INIT: cfg_q.sync_counter_init <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	e2e1_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.rec_valid (rec_valid),
		.rec       (rec_in)
	);

	e2e1_fifo #(
		.WIDTH ($bits(frame_rec_t)),
		.DEPTH (FRAME_QUEUE_DEPTH)
	) u_frame_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (rec_in),
		.full    (full),
		.rd_en   (take),
		.rd_data (rec_out),
		.empty   (frq_empty)
	);

	assign take = !frq_empty && !rq_full;

	e2e1_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.rec    (rec_out),
		.res    (res_in)
	);

	e2e1_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (res_in),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign check_status     = res_out.status;
	assign received_counter = res_out.counter;

endmodule

// ===== rtl/e2e1_fifo.sv =====
// small first-word-fall-through queue of flip-flops
// generic; used for the frame queue and the result queue

module e2e1_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/e2e1_front.sv =====
// front end: byte position, crc accumulation and counter capture per item
// depends on e2e1_pkg; emits one frame record at each frame end

module e2e1_front
	import e2e1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output logic       rec_valid,
	output frame_rec_t rec
);

	logic [7:0] pos_q;
	logic [7:0] acc_q;
	logic [7:0] rx_crc_q;
	logic [3:0] cnt_q;

	logic       first;
	logic [7:0] acc_n;
	logic [7:0] rx_crc_n;
	logic [3:0] cnt_n;
	logic [8:0] byte_count;

	assign first = (pos_q == '0);

	always_comb begin
		// a new frame restarts from the crc of the id
		acc_n    = first ? cfg.crc_id : acc_q;
		rx_crc_n = first ? 8'h00 : rx_crc_q;
		cnt_n    = first ? 4'h0 : cnt_q;
		if (pos_q == cfg.crc_offset) begin
			rx_crc_n = data_byte;
		end else if (pos_q < cfg.data_length) begin
			acc_n = crc8_byte(acc_n, data_byte);
		end
		if (pos_q == cfg.counter_offset) begin
			cnt_n = data_byte[3:0];
		end
	end

	// nine bits, so a saturated position still never reads as short
	assign byte_count = {1'b0, pos_q} + 9'd1;

	assign rec_valid       = accept && frame_end;
	assign rec.short_frame = (byte_count < {1'b0, cfg.data_length});
	assign rec.crc_ok      = (acc_n == rx_crc_n);
	assign rec.counter     = cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q <= '0;
			end else if (pos_q != 8'hFF) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q    <= acc_n;
			rx_crc_q <= rx_crc_n;
			cnt_q    <= cnt_n;
		end
	end

endmodule

// ===== rtl/e2e1_back.sv =====
// back end: counter sequence judgement, one record per cycle on take
// depends on e2e1_pkg; fed from the frame queue, writes the result queue

module e2e1_back
	import e2e1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  frame_rec_t rec,
	output result_t    res
);

	logic [3:0] last_q;
	logic       awaiting_q;
	logic [7:0] resync_q;

	logic [4:0] delta_wide;
	logic [3:0] delta;
	logic       adopt;
	logic       load_resync;
	logic       dec_resync;

	// delta modulo 15, the counter runs 0..14
	assign delta_wide = (rec.counter >= last_q) ?
		{1'b0, rec.counter} - {1'b0, last_q} :
		5'd15 + {1'b0, rec.counter} - {1'b0, last_q};
	assign delta = delta_wide[3:0];

	always_comb begin
		adopt       = 1'b0;
		load_resync = 1'b0;
		dec_resync  = 1'b0;
		res.counter = rec.counter;
		if (rec.short_frame) begin
			res.status  = ST_ERROR;
			res.counter = 4'h0;
		end else if (!rec.crc_ok) begin
			res.status = ST_WRONGCRC;
		end else if (awaiting_q) begin
			res.status = ST_INITIAL;
			adopt      = 1'b1;
		end else if (delta == 4'h0) begin
			res.status = ST_REPEATED;
		end else if (delta > cfg.max_delta_counter) begin
			res.status  = ST_WRONGSEQUENCE;
			adopt       = 1'b1;
			load_resync = 1'b1;
		end else if (resync_q != '0) begin
			res.status = ST_SYNC;
			adopt      = 1'b1;
			dec_resync = 1'b1;
		end else begin
			res.status = (delta == 4'h1) ? ST_OK : ST_OKSOMELOST;
			adopt      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			awaiting_q <= 1'b1;
			resync_q   <= '0;
		end else if (take) begin
			if (adopt) begin
				last_q <= rec.counter;
			end
			if (awaiting_q && adopt) begin
				awaiting_q <= 1'b0;
				resync_q   <= '0;
			end else if (load_resync) begin
				resync_q <= cfg.sync_counter_init;
			end else if (dec_resync) begin
				resync_q <= resync_q - 8'd1;
			end
		end
	end

endmodule

// ===== tb/sv/e2e_profile1_frame_checker_top_tb.sv =====
// self-checking testbench for e2e_profile1_frame_checker_top: directed frame table, then random
// frames under several register settings, each status checked against its table row or a predictor
// depends on e2e1_pkg and the rtl of the block
`timescale 1ns / 1ps

module e2e_profile1_frame_checker_top_tb;
	import e2e1_pkg::*;

	localparam int N_DIR          = 25;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {FILL_RAW, FILL_GOOD, FILL_BAD} crc_fill_e;

	typedef struct {
		logic [7:0] b;
		logic       fe;
		crc_fill_e  fill;
		bit         typed;
		status_t    st;
		logic [3:0] ctr;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	logic                  full;
	logic [7:0]            data_byte;
	logic                  frame_end;
	logic                  empty;
	logic                  pop;
	logic [2:0]            check_status;
	logic [3:0]            received_counter;

	// register copies
	logic [15:0] c_id;
	logic [7:0]  c_len;
	logic [7:0]  c_crc_off;
	logic [7:0]  c_ctr_off;
	logic [3:0]  c_max_delta;
	logic [7:0]  c_sync_init;

	// frame and sequence state of the predictor
	logic [7:0] fr_pos;
	logic [7:0] fr_crc;
	logic [7:0] fr_rx_crc;
	logic [3:0] fr_ctr;
	logic [3:0] last_ctr;
	logic       first_pending;
	logic [7:0] resync_left;

	result_t due_results[$];
	dir_row_t dir_rows [N_DIR];

	int  errors;
	int  n_items;
	int  n_results;
	int  n_settings;
	int  ctr_hint;
	bit  calm;
	int  hold_asks;
	int  holds_served;

	e2e_profile1_frame_checker_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.push             (push),
		.full             (full),
		.data_byte        (data_byte),
		.frame_end        (frame_end),
		.empty            (empty),
		.pop              (pop),
		.check_status     (check_status),
		.received_counter (received_counter)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] id_crc(input logic [15:0] id);
		return crc_next(crc_next(8'h00, id[7:0]), id[15:8]);
	endfunction

	// counter delta runs modulo 15, nibble value 15 goes through the same rule
	function automatic status_t judge_counter(input logic [3:0] rc);
		logic [3:0] delta;
		if (first_pending) begin
			last_ctr      = rc;
			first_pending = 1'b0;
			resync_left   = 8'd0;
			return ST_INITIAL;
		end
		if (rc >= last_ctr) begin
			delta = rc - last_ctr;
		end else begin
			delta = 4'(15 + int'(rc) - int'(last_ctr));
		end
		if (delta == 4'd0) begin
			return ST_REPEATED;
		end
		if (delta > c_max_delta) begin
			last_ctr    = rc;
			resync_left = c_sync_init;
			return ST_WRONGSEQUENCE;
		end
		last_ctr = rc;
		if (resync_left != 8'd0) begin
			resync_left = resync_left - 8'd1;
			return ST_SYNC;
		end
		return (delta == 4'd1) ? ST_OK : ST_OKSOMELOST;
	endfunction

	function automatic bit predict_byte(input logic [7:0] b, input logic fe, output result_t r);
		int cnt;
		logic [7:0] p;
		p = fr_pos;
		r = '0;
		if (p == 8'd0) begin
			fr_crc    = id_crc(c_id);
			fr_rx_crc = 8'd0;
			fr_ctr    = 4'd0;
		end
		if (p == c_crc_off) begin
			fr_rx_crc = b;
		end else if (p < c_len) begin
			fr_crc = crc_next(fr_crc, b);
		end
		if (p == c_ctr_off) begin
			fr_ctr = b[3:0];
		end
		if (p != 8'hFF) begin
			fr_pos = p + 8'd1;
		end
		if (!fe) begin
			return 1'b0;
		end
		fr_pos = 8'd0;
		cnt = int'(p) + 1;
		if (cnt > 255) begin
			cnt = 255;
		end
		if (cnt < int'(c_len)) begin
			r.status  = ST_ERROR;
			r.counter = 4'd0;
		end else begin
			r.counter = fr_ctr;
			if (fr_crc != fr_rx_crc) begin
				r.status = ST_WRONGCRC;
			end else begin
				r.status = judge_counter(fr_ctr);
			end
		end
		return 1'b1;
	endfunction

	// mostly back to back, some short gaps, a few long ones; no gaps while calm
	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input logic [7:0] b, input logic fe, input bit typed,
			input result_t fixed);
		int gap;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		frame_end <= fe;
		@(posedge clk);
		while (full) @(posedge clk);
		n_items++;
		if (predict_byte(b, fe, r)) begin
			due_results.push_back(typed ? fixed : r);
		end
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_ADDR_W-1:0] a, input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= v;
		@(negedge clk);
	endtask

	task automatic load_config(input logic [15:0] id, input logic [7:0] len,
			input logic [7:0] crco, input logic [7:0] ctro, input logic [3:0] md,
			input logic [7:0] sync);
		put_reg(REG_DATA_ID, id);
		put_reg(REG_DATA_LENGTH, {8'h00, len});
		put_reg(REG_CRC_OFFSET, {8'h00, crco});
		put_reg(REG_COUNTER_OFFSET, {8'h00, ctro});
		put_reg(REG_MAX_DELTA_COUNTER, {12'h000, md});
		put_reg(REG_SYNC_COUNTER_INIT, {8'h00, sync});
		cfg_we      <= 1'b0;
		c_id        = id;
		c_len       = len;
		c_crc_off   = crco;
		c_ctr_off   = ctro;
		c_max_delta = md;
		c_sync_init = sync;
		n_settings++;
	endtask

	// drain every pending status, then let the pipeline run dry
	task automatic settle();
		push <= 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_frame(input int len, input logic [3:0] ctr, input bit spoil);
		logic [7:0] fb [];
		logic [7:0] acc;
		fb = new[len];
		foreach (fb[i]) begin
			fb[i] = 8'($urandom);
		end
		if (int'(c_ctr_off) < len) begin
			fb[c_ctr_off][3:0] = ctr;
		end
		acc = id_crc(c_id);
		for (int i = 0; i < len && i < int'(c_len); i++) begin
			if (i != int'(c_crc_off)) begin
				acc = crc_next(acc, fb[i]);
			end
		end
		// crc byte only lands if the frame reaches its offset
		if (int'(c_crc_off) < len) begin
			fb[c_crc_off] = spoil ? (acc ^ 8'($urandom_range(1, 255))) : acc;
		end
		for (int i = 0; i < len; i++) begin
			send_item(fb[i], i == len - 1, 1'b0, '0);
		end
	endtask

	task automatic run_random_phase(input int n_bytes);
		int sent;
		int len;
		int r;
		int d;
		logic [3:0] ctr;
		sent = 0;
		while (sent < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				len = c_len;
			end else if (r < 87) begin
				len = (c_len > 1) ? $urandom_range(1, c_len - 1) : c_len;
			end else begin
				len = c_len + $urandom_range(1, 4);
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				d   = $urandom_range(1, (c_max_delta > 1) ? c_max_delta : 1);
				ctr = 4'((ctr_hint + d) % 15);
			end else if (r < 70) begin
				ctr = 4'(ctr_hint);
			end else if (r < 82) begin
				ctr = 4'($urandom_range(0, 14));
			end else if (r < 88) begin
				ctr = 4'd15;
			end else begin
				ctr = 4'($urandom_range(0, 15));
			end
			send_frame(len, ctr, $urandom_range(0, 99) < 12);
			sent += len;
			ctr_hint = ctr;
		end
	endtask

	initial begin : stimulus
		dir_row_t row;
		logic [7:0] b;
		result_t fixed;
		int len;
		logic [7:0] crco;
		logic [7:0] ctro;
		logic [7:0] sync;
		int pick;

		push      = 1'b0;
		data_byte = 8'h00;
		frame_end = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_DATA_ID;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		errors    = 0;
		n_items   = 0;
		n_settings = 0;
		ctr_hint  = 0;
		calm      = 1'b0;
		hold_asks = 0;

		c_id          = 16'h0000;
		c_len         = 8'd8;
		c_crc_off     = 8'd0;
		c_ctr_off     = 8'd1;
		c_max_delta   = 4'd1;
		c_sync_init   = 8'd0;
		fr_pos        = 8'd0;
		fr_crc        = id_crc(16'h0000);
		fr_rx_crc     = 8'd0;
		fr_ctr        = 4'd0;
		last_ctr      = 4'd0;
		first_pending = 1'b1;
		resync_left   = 8'd0;

		// data length 2: counter at 0, crc at 1; window 2, two sync frames after a jump
		dir_rows = '{
			'{8'hFF, 1'b1, FILL_RAW,  1'b1, ST_ERROR,    4'd0},  // short frame
			'{8'h00, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b1, ST_INITIAL,  4'd0},
			'{8'hF0, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b1, ST_REPEATED, 4'd0},
			'{8'h01, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'h03, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'h47, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'hA8, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_BAD,  1'b1, ST_WRONGCRC, 4'd8},
			'{8'h08, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'h0F, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},  // counter nibble 15
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'h01, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},  // wraps past 14
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'h02, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},  // long frame, tail ignored
			'{8'h00, 1'b0, FILL_GOOD, 1'b0, ST_OK,       4'd0},
			'{8'h7E, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'hFF, 1'b1, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h03, 1'b0, FILL_RAW,  1'b0, ST_OK,       4'd0},
			'{8'h00, 1'b1, FILL_GOOD, 1'b0, ST_OK,       4'd0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_config(16'h5A3C, 8'd2, 8'd1, 8'd0, 4'd2, 8'd2);
		for (int i = 0; i < N_DIR; i++) begin
			row = dir_rows[i];
			b = row.b;
			// crc rows take the running crc of the bytes already sent
			if (row.fill == FILL_GOOD) begin
				b = fr_crc;
			end else if (row.fill == FILL_BAD) begin
				b = fr_crc ^ 8'h5A;
			end
			fixed.status  = row.st;
			fixed.counter = row.ctr;
			send_item(b, row.fe, row.typed, fixed);
		end
		settle();

		// data length 1; the receiver holds off so the block backs up
		load_config(16'h0000, 8'd1, 8'd0, 8'd0, 4'd0, 8'd0);
		hold_asks++;
		run_random_phase(80);
		settle();

		// largest length, a frame past the saturating position and a short one
		load_config(16'hFFFF, 8'd255, 8'd254, 8'd0, 4'd15, 8'd255);
		send_frame(270, 4'(($urandom_range(0, 14))), 1'b0);
		send_frame(40, 4'(($urandom_range(0, 14))), 1'b0);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			len  = $urandom_range(2, 10);
			crco = 8'($urandom_range(0, len - 1));
			ctro = 8'($urandom_range(0, len - 1));
			if (ph == 2) begin
				// offsets past the protected length
				crco = 8'(len + $urandom_range(0, 2));
				ctro = 8'(len + $urandom_range(0, 3));
			end
			pick = $urandom_range(0, 3);
			case (pick)
				0: begin
					sync = 8'd0;
				end
				1: begin
					sync = 8'($urandom_range(1, 3));
				end
				2: begin
					sync = 8'd255;
				end
				default: begin
					sync = 8'($urandom_range(0, 255));
				end
			endcase
			load_config(16'($urandom), 8'(len), crco, ctro,
				(ph == 0) ? 4'd15 : 4'($urandom_range(0, 15)), sync);
			calm = (ph == 1);
			run_random_phase(55);
			calm = 1'b0;
			settle();
		end

		while (due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("run: %0d bytes pushed, %0d statuses popped, %0d register settings",
			n_items, n_results, n_settings);
		$display("covered: extreme lengths and ids, short, long and corrupted frames, counter jumps");
		if (errors == 0) begin
			$display("e2e_profile1_frame_checker_top test passed");
		end else begin
			$display("e2e_profile1_frame_checker_top test failed");
		end
		$finish;
	end

	initial begin : result_sink
		int gap;
		result_t want;
		pop = 1'b0;
		n_results = 0;
		holds_served = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_asks != holds_served) begin
				holds_served++;
				gap = HOLD_CYCLES;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			n_results++;
			if (due_results.size() == 0) begin
				$display("%0t: status item with none expected: status %0d counter %0d",
					$time, check_status, received_counter);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (check_status !== want.status) begin
					$display("%0t: check_status expected %0d got %0d",
						$time, want.status, check_status);
					errors++;
				end
				if (received_counter !== want.counter) begin
					$display("%0t: received_counter expected %0d got %0d",
						$time, want.counter, received_counter);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no item moved for %0d cycles, %0d statuses still due",
			$time, WATCHDOG_LIMIT, due_results.size());
		$display("e2e_profile1_frame_checker_top test failed");
		$finish;
	end

endmodule
